>>> rtl/bcdasc_pkg.sv
package bcdasc_pkg;

  localparam int DIGIT_W    = 4;
  localparam int WORD_W     = 32;
  localparam int GRP_DIGITS = 4;
  localparam int BYTE_DIGITS = 3;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_SUB  = 2'd1;
  localparam logic [1:0] REQ_CMP  = 2'd2;
  localparam logic [1:0] REQ_CONV = 2'd3;

  // Carry and compare summary of one group of four digits.
  typedef struct packed {
    logic [GRP_DIGITS-1:0] c_loc;  // carry into each digit with no carry into the group
    logic [GRP_DIGITS-1:0] pp;     // every lower digit in the group propagates
    logic                  gen;
    logic                  prop;
    logic                  lt;
    logic                  eq;
  } grp_t;

  function automatic logic [DIGIT_W-1:0] clamp9(input logic [DIGIT_W-1:0] d);
    return (d > 4'd9) ? 4'd9 : d;
  endfunction

  // Shift-and-add-3 conversion of one byte into three BCD digits.
  function automatic logic [BYTE_DIGITS*DIGIT_W-1:0] bin_to_bcd3(input logic [7:0] v);
    logic [BYTE_DIGITS*DIGIT_W+7:0] sh;
    sh = {{(BYTE_DIGITS*DIGIT_W){1'b0}}, v};
    for (int i = 0; i < 8; i++) begin
      for (int d = 0; d < BYTE_DIGITS; d++) begin
        if (sh[8+DIGIT_W*d +: DIGIT_W] >= 4'd5) begin
          sh[8+DIGIT_W*d +: DIGIT_W] = sh[8+DIGIT_W*d +: DIGIT_W] + 4'd3;
        end
      end
      sh = sh << 1;
    end
    return sh[BYTE_DIGITS*DIGIT_W+7:8];
  endfunction

endpackage

>>> rtl/bcdasc_group.sv
module bcdasc_group (
  input  logic [bcdasc_pkg::GRP_DIGITS-1:0] g,
  input  logic [bcdasc_pkg::GRP_DIGITS-1:0] p,
  input  logic [bcdasc_pkg::GRP_DIGITS-1:0] lt,
  input  logic [bcdasc_pkg::GRP_DIGITS-1:0] eq,
  output bcdasc_pkg::grp_t                  grp
);
  import bcdasc_pkg::*;

  logic c;
  logic pr;

  always_comb begin
    grp = '0;
    c   = 1'b0;
    pr  = 1'b1;
    for (int k = 0; k < GRP_DIGITS; k++) begin
      grp.c_loc[k] = c;
      grp.pp[k]    = pr;
      c  = g[k] | (p[k] & c);
      pr = pr & p[k];
    end
    grp.gen  = c;
    grp.prop = pr;

    // The highest digit that differs decides the order.
    grp.eq = 1'b1;
    grp.lt = 1'b0;
    for (int k = GRP_DIGITS - 1; k >= 0; k--) begin
      if (grp.eq && !eq[k]) begin
        grp.lt = lt[k];
        grp.eq = 1'b0;
      end
    end
  end

endmodule

>>> rtl/bcd_fixed_point_add_sub_compare_unit.sv
// Packed BCD fixed-point unit: add, subtract, compare, and byte-to-BCD convert.
// A number holds INT_DIGITS integer digits above FRAC_DIGITS fraction digits,
// four bits per digit, least significant fraction digit in the lowest nibble.
// A request is taken at a rising edge where start is high and busy is low.
// busy is high only while reset is applied and in the first cycle after it;
// otherwise a new request may be issued in every cycle.
// Each request gives one result after it passes the three register stages
// (digit prepare, group carry lookahead, final carry and digit correction):
// out_valid is high for exactly one cycle with the result fields beside it.
// The unit takes one request per cycle.
// Add and subtract wrap at the top digit and report carry or borrow on
// out_carry_out; compare reports out_a_less and out_a_equal with a zero
// number. The receiver cannot stall the unit, so nothing is ever held back.
// Reset empties the pipeline; requests in flight are dropped.
module bcd_fixed_point_add_sub_compare_unit #(
  parameter int INT_DIGITS  = 4,
  parameter int FRAC_DIGITS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_req_type,
  input  logic [bcdasc_pkg::WORD_W-1:0] in_operand_a,
  input  logic [bcdasc_pkg::WORD_W-1:0] in_operand_b,
  input  logic [7:0]                in_bin_int,
  input  logic [7:0]                in_bin_frac,
  output logic                      out_valid,
  output logic [bcdasc_pkg::WORD_W-1:0] out_result_bcd,
  output logic                      out_carry_out,
  output logic                      out_a_less,
  output logic                      out_a_equal
);
  import bcdasc_pkg::*;

  localparam int TD = INT_DIGITS + FRAC_DIGITS;
  localparam int NG = (TD + GRP_DIGITS - 1) / GRP_DIGITS;
  localparam int ND = NG * GRP_DIGITS;
  localparam int XW = ((ND > 8) ? ND : 8) * DIGIT_W;

  logic busy_r;
  logic accept;

  // Stage one: per-digit sums, generate and propagate, compare bits.
  logic                s1_valid_r;
  logic [1:0]          s1_op_r;
  logic [ND-1:0][4:0]  s1_sum_r, s1_sum_nxt;
  logic [ND-1:0]       s1_g_r, s1_g_nxt;
  logic [ND-1:0]       s1_p_r, s1_p_nxt;
  logic [ND-1:0]       s1_lt_r, s1_lt_nxt;
  logic [ND-1:0]       s1_eq_r, s1_eq_nxt;
  logic [WORD_W-1:0]   s1_conv_r, s1_conv_nxt;

  // Stage two: group lookahead.
  logic                s2_valid_r;
  logic [1:0]          s2_op_r;
  logic [ND-1:0][4:0]  s2_sum_r;
  logic [ND-1:0]       s2_g_r;
  logic [ND-1:0]       s2_p_r;
  logic [WORD_W-1:0]   s2_conv_r;
  grp_t                s2_grp_r [NG];
  grp_t                grp_w [NG];

  // Stage three: output registers.
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_result_r, out_result_nxt;
  logic                out_carry_r, out_carry_nxt;
  logic                out_less_r, out_less_nxt;
  logic                out_equal_r, out_equal_nxt;

  logic [XW-1:0]       a_ext, b_ext;
  logic [XW-1:0]       conv_ext, res_ext;
  logic [BYTE_DIGITS*DIGIT_W-1:0] bf_bcd, bi_bcd;
  logic [DIGIT_W-1:0]  x, y, xr, yr;
  logic [NG-1:0]       gc;
  logic [ND-1:0]       cin;
  logic [4:0]          t;
  logic [ND*DIGIT_W-1:0] dig;
  logic                c_less, c_equal;

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  assign a_ext  = XW'(in_operand_a);
  assign b_ext  = XW'(in_operand_b);
  assign bf_bcd = bin_to_bcd3(in_bin_frac);
  assign bi_bcd = bin_to_bcd3(in_bin_int);

  always_comb begin
    s1_sum_nxt = '0;
    s1_g_nxt   = '0;
    s1_p_nxt   = '0;
    s1_lt_nxt  = '0;
    s1_eq_nxt  = '1;
    conv_ext   = '0;
    x  = '0;
    y  = '0;
    xr = '0;
    yr = '0;
    for (int k = 0; k < ND; k++) begin
      if (k < TD) begin
        xr = a_ext[DIGIT_W*k +: DIGIT_W];
        yr = b_ext[DIGIT_W*k +: DIGIT_W];
      end else begin
        xr = '0;
        yr = '0;
      end
      x = clamp9(xr);
      y = clamp9(yr);
      s1_lt_nxt[k] = (xr < yr);
      s1_eq_nxt[k] = (xr == yr);
      if (in_req_type == REQ_SUB) begin
        s1_sum_nxt[k] = {1'b0, x} - {1'b0, y};
        s1_g_nxt[k]   = (x < y);
        s1_p_nxt[k]   = (x == y);
      end else begin
        s1_sum_nxt[k] = {1'b0, x} + {1'b0, y};
        s1_g_nxt[k]   = (s1_sum_nxt[k] >= 5'd10);
        s1_p_nxt[k]   = (s1_sum_nxt[k] == 5'd9);
      end
    end
    for (int k = 0; k < TD; k++) begin
      if (k < FRAC_DIGITS) begin
        if (k < BYTE_DIGITS) begin
          conv_ext[DIGIT_W*k +: DIGIT_W] = bf_bcd[DIGIT_W*k +: DIGIT_W];
        end
      end else if (k - FRAC_DIGITS < BYTE_DIGITS) begin
        conv_ext[DIGIT_W*k +: DIGIT_W] = bi_bcd[DIGIT_W*(k-FRAC_DIGITS) +: DIGIT_W];
      end
    end
    s1_conv_nxt = conv_ext[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      s1_valid_r <= accept;
    end
    s1_op_r   <= in_req_type;
    s1_sum_r  <= s1_sum_nxt;
    s1_g_r    <= s1_g_nxt;
    s1_p_r    <= s1_p_nxt;
    s1_lt_r   <= s1_lt_nxt;
    s1_eq_r   <= s1_eq_nxt;
    s1_conv_r <= s1_conv_nxt;
  end

  for (genvar j = 0; j < NG; j++) begin : g_grp
    bcdasc_group u_grp (
      .g   (s1_g_r[GRP_DIGITS*j +: GRP_DIGITS]),
      .p   (s1_p_r[GRP_DIGITS*j +: GRP_DIGITS]),
      .lt  (s1_lt_r[GRP_DIGITS*j +: GRP_DIGITS]),
      .eq  (s1_eq_r[GRP_DIGITS*j +: GRP_DIGITS]),
      .grp (grp_w[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_op_r   <= s1_op_r;
    s2_sum_r  <= s1_sum_r;
    s2_g_r    <= s1_g_r;
    s2_p_r    <= s1_p_r;
    s2_conv_r <= s1_conv_r;
    s2_grp_r  <= grp_w;
  end

  always_comb begin
    gc[0] = 1'b0;
    for (int j = 0; j + 1 < NG; j++) begin
      gc[j+1] = s2_grp_r[j].gen | (s2_grp_r[j].prop & gc[j]);
    end

    cin = '0;
    dig = '0;
    t   = '0;
    for (int k = 0; k < ND; k++) begin
      cin[k] = s2_grp_r[k / GRP_DIGITS].c_loc[k % GRP_DIGITS] |
               (s2_grp_r[k / GRP_DIGITS].pp[k % GRP_DIGITS] & gc[k / GRP_DIGITS]);
      if (s2_op_r == REQ_SUB) begin
        t = s2_sum_r[k] - {4'd0, cin[k]};
        // A negative digit difference borrows ten from the next digit.
        if (t[4]) begin
          t = t + 5'd10;
        end
      end else begin
        t = s2_sum_r[k] + {4'd0, cin[k]};
        if (t >= 5'd10) begin
          t = t - 5'd10;
        end
      end
      // Padding digits above the top digit stay zero even when a carry reaches them.
      if (k < TD) begin
        dig[DIGIT_W*k +: DIGIT_W] = t[DIGIT_W-1:0];
      end
    end
    res_ext = XW'(dig);

    c_less  = 1'b0;
    c_equal = 1'b1;
    for (int j = NG - 1; j >= 0; j--) begin
      if (c_equal && !s2_grp_r[j].eq) begin
        c_less  = s2_grp_r[j].lt;
        c_equal = 1'b0;
      end
    end

    out_result_nxt = '0;
    out_carry_nxt  = 1'b0;
    out_less_nxt   = 1'b0;
    out_equal_nxt  = 1'b0;
    case (s2_op_r)
      REQ_ADD, REQ_SUB: begin
        out_result_nxt = res_ext[WORD_W-1:0];
        out_carry_nxt  = s2_g_r[TD-1] | (s2_p_r[TD-1] & cin[TD-1]);
      end
      REQ_CMP: begin
        out_less_nxt  = c_less;
        out_equal_nxt = c_equal;
      end
      default: begin
        out_result_nxt = s2_conv_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
    out_result_r <= out_result_nxt;
    out_carry_r  <= out_carry_nxt;
    out_less_r   <= out_less_nxt;
    out_equal_r  <= out_equal_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_result_bcd = out_result_r;
  assign out_carry_out  = out_carry_r;
  assign out_a_less     = out_less_r;
  assign out_a_equal    = out_equal_r;

endmodule

>>> rtl/bcdasc_chk.sv
module bcdasc_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    in_req_type,
  input logic                          out_valid,
  input logic [bcdasc_pkg::WORD_W-1:0] out_result_bcd,
  input logic                          out_carry_out,
  input logic                          out_a_less,
  input logic                          out_a_equal
);
  import bcdasc_pkg::*;

  // Every request taken gives its result on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("request did not produce a result after three cycles");

  // No result appears without a matching request taken before it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a matching request");

  a_cmp_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_a_less && out_a_equal))
    else $error("compare reports both less and equal");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_req_type, 3) == REQ_CMP) |->
      (out_result_bcd == '0 && !out_carry_out))
    else $error("compare result carries a number or a carry");

  a_arith_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_req_type, 3) != REQ_CMP) |-> (!out_a_less && !out_a_equal))
    else $error("compare flags set outside a compare request");

endmodule

bind bcd_fixed_point_add_sub_compare_unit bcdasc_chk u_bcdasc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_result_bcd (out_result_bcd),
  .out_carry_out  (out_carry_out),
  .out_a_less     (out_a_less),
  .out_a_equal    (out_a_equal)
);
